[hw/rtl/lsw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the weighted move-to-front stack block.
package lsw_pkg;

    localparam int ITEM_W   = 10;
    localparam int WT_IN_W  = 16;
    localparam int COST_W   = 25;
    localparam int TOTAL_W  = 48;

    localparam logic [COST_W-1:0]  COST_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Per-cycle command broadcast to every cell of the stack row.
    typedef struct packed {
        logic read_go;   // move key to top
        logic load_go;   // weight update of key
        logic clear;     // drop the whole stack
        logic hit;       // key is on the stack
    } lsw_ctrl_t;

endpackage

[hw/rtl/lru_stack_weighted_depth_top.sv]
`timescale 1ns / 1ps
// Top level of the weighted move-to-front stack distance block.
//
// Keeps a move-to-front stack of item ids in a row of NUM_ITEMS cells and a weight
// per item in a RAM. A load item (kind 0) sets one weight and returns nothing; a read
// item (kind 1) returns the summed weight of every item above the read one
// (lift_cost, saturated), the saturating sequence total, and whether this is the first
// read of the item, then moves the item to the top. A read with final_req set ends the
// sequence after its result: stack and total are cleared, weights are kept. Ids of 0 or
// above NUM_ITEMS give no result and change nothing, except that final_req on such a
// read still clears the sequence. Each cell carries the weight sum of the positions
// above it, so a read needs no wide adder tree: the match state compares the id across
// the row, the update state moves the cells and applies the update. An item therefore
// passes through idle, match and update before the next one is accepted; a read's
// update waits only while a previous result is still held at the output and out_ready
// is low. After reset the weight RAM is zeroed by a clearing pass over all NUM_ITEMS
// entries, during which in_ready stays low.
module lru_stack_weighted_depth_top #(
    parameter int NUM_ITEMS   = 512,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [lsw_pkg::ITEM_W-1:0]    item,
    input  logic [lsw_pkg::WT_IN_W-1:0]   weight,
    input  logic                          final_req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsw_pkg::COST_W-1:0]    lift_cost,
    output logic [lsw_pkg::TOTAL_W-1:0]   running_total,
    output logic                          first_access
);

    import lsw_pkg::*;

    localparam int IDW = $clog2(NUM_ITEMS);
    localparam int WW  = WEIGHT_BITS;
    // Sum of up to NUM_ITEMS weights fits without overflow.
    localparam int PW  = WEIGHT_BITS + IDW;
    localparam int EW  = (PW > TOTAL_W) ? PW : TOTAL_W;
    localparam int XW  = ((ITEM_W > IDW) ? ITEM_W : IDW) + 1;

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,   // weight RAM clearing pass
        S_IDLE   = 4'b0010,
        S_MATCH  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IDW-1:0]     clr_cnt_reg;
    logic [IDW-1:0]     clr_cnt_next;

    // Accepted item
    logic               kind_reg;
    logic               ok_reg;
    logic               final_reg;
    logic [IDW-1:0]     key_reg;
    logic [WW-1:0]      ldw_reg;

    // Match results
    logic               hit_reg;
    logic [IDW-1:0]     pos_reg;
    logic [WW-1:0]      selw_reg;
    logic [PW-1:0]      selp_reg;

    // Sequence state
    logic [PW-1:0]      sum_reg;        // weight sum of whole stack
    logic [PW-1:0]      sum_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    // Output stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COST_W-1:0]  lift_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic               first_reg;

    logic [XW-1:0]      item_ext;
    logic               item_ok;
    logic [IDW-1:0]     item_idx;
    logic               accept;

    logic               ram_we;
    logic [IDW-1:0]     ram_waddr;
    logic [WW-1:0]      ram_wdata;
    logic [WW-1:0]      ram_wt;

    logic               is_read_ok;
    logic               is_load_ok;
    logic               upd_go;
    lsw_ctrl_t          ctrl;
    logic [WW-1:0]      cell_wt;
    logic [PW-1:0]      delta;
    logic [PW-1:0]      cost;
    logic [EW:0]        cost_e;
    logic [EW:0]        tot_wide;
    logic [TOTAL_W-1:0] tot_new;
    logic [COST_W-1:0]  lift_new;

    logic               row_hit;
    logic [IDW-1:0]     row_pos;
    logic [WW-1:0]      row_wt;
    logic [PW-1:0]      row_pfx;

    // Input decode: ids run from 1, index from 0.
    always_comb
    begin
        item_ext = XW'(item);
        item_ok  = (item_ext != '0) && (item_ext <= XW'(NUM_ITEMS));
        item_idx = IDW'(item_ext - XW'(1));
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Update step control; a read waits while the output register is still full and out_ready is low.
    always_comb
    begin
        is_read_ok   = (kind_reg == KIND_READ) && ok_reg;
        is_load_ok   = (kind_reg == KIND_LOAD) && ok_reg;
        upd_go       = (state_reg == S_UPDATE) &&
                       !(is_read_ok && out_valid_reg && !out_ready);
        ctrl.read_go = upd_go && is_read_ok;
        ctrl.load_go = upd_go && is_load_ok;
        ctrl.clear   = upd_go && (kind_reg == KIND_READ) && final_reg;
        ctrl.hit     = hit_reg;
    end

    always_comb
    begin
        if (kind_reg == KIND_LOAD)
        begin
            cell_wt = ldw_reg;
        end
        else if (hit_reg)
        begin
            cell_wt = selw_reg;
        end
        else
        begin
            cell_wt = ram_wt;
        end
        // Modular: prefix sums below the changed cell stay exact.
        delta = PW'(ldw_reg) - PW'(selw_reg);
        // A first read costs the whole stack.
        cost  = hit_reg ? selp_reg : sum_reg;
    end

    // Cost saturation and saturating total
    always_comb
    begin
        cost_e   = (EW+1)'(cost);
        tot_wide = (EW+1)'(total_reg) + cost_e;
        if (tot_wide >= (EW+1)'(TOTAL_MAX))
        begin
            tot_new = TOTAL_MAX;
        end
        else
        begin
            tot_new = TOTAL_W'(tot_wide);
        end
        if (cost_e > (EW+1)'(COST_MAX))
        begin
            lift_new = COST_MAX;
        end
        else
        begin
            lift_new = COST_W'(cost);
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        total_next = total_reg;
        if (ctrl.clear)
        begin
            sum_next   = '0;
            total_next = '0;
        end
        else if (ctrl.read_go)
        begin
            total_next = tot_new;
            if (!hit_reg)
            begin
                sum_next = sum_reg + PW'(ram_wt);
            end
        end
        else if (ctrl.load_go && hit_reg)
        begin
            sum_next = sum_reg + delta;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.read_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + IDW'(1);
                if (clr_cnt_reg == IDW'(NUM_ITEMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            ok_reg    <= item_ok;
            final_reg <= final_req;
            key_reg   <= item_idx;
            ldw_reg   <= WW'(weight);
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg  <= row_hit;
            pos_reg  <= row_pos;
            selw_reg <= row_wt;
            selp_reg <= row_pfx;
        end
        if (ctrl.read_go)
        begin
            lift_reg      <= lift_new;
            out_total_reg <= tot_new;
            first_reg     <= !hit_reg;
        end
    end

    // Weight table: zeroed by the clearing pass, written by loads.
    always_comb
    begin
        ram_we    = (state_reg == S_INIT) || ctrl.load_go;
        ram_waddr = (state_reg == S_INIT) ? clr_cnt_reg : key_reg;
        ram_wdata = (state_reg == S_INIT) ? '0 : ldw_reg;
    end

    lsw_ram #(
        .WIDTH (WW),
        .DEPTH (NUM_ITEMS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (item_idx),
        .rdata (ram_wt)
    );

    lsw_row #(
        .NUM_ITEMS (NUM_ITEMS),
        .IDW       (IDW),
        .WW        (WW),
        .PW        (PW)
    ) u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key     (key_reg),
        .pos     (pos_reg),
        .new_wt  (cell_wt),
        .delta   (delta),
        .hit_any (row_hit),
        .hit_pos (row_pos),
        .hit_wt  (row_wt),
        .hit_pfx (row_pfx)
    );

    assign out_valid     = out_valid_reg;
    assign lift_cost     = lift_reg;
    assign running_total = out_total_reg;
    assign first_access  = first_reg;

endmodule

[hw/rtl/lsw_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lsw_cell.sv]
`timescale 1ns / 1ps
// One stack position: item id, its weight and the weight sum of all positions above it.
module lsw_cell #(
    parameter int IDW   = 9,
    parameter int WW    = 16,
    parameter int PW    = 25,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lsw_pkg::lsw_ctrl_t ctrl,
    input  logic [IDW-1:0]    key,
    input  logic [IDW-1:0]    pos,
    input  logic [WW-1:0]     new_wt,
    input  logic [PW-1:0]     delta,
    input  logic              prev_valid,
    input  logic [IDW-1:0]    prev_id,
    input  logic [WW-1:0]     prev_wt,
    input  logic [PW-1:0]     prev_pfx,
    output logic              valid,
    output logic [IDW-1:0]    id,
    output logic [WW-1:0]     wt,
    output logic [PW-1:0]     pfx,
    output logic              hit
);

    import lsw_pkg::*;

    logic           valid_reg;
    logic [IDW-1:0] id_reg;
    logic [WW-1:0]  wt_reg;
    logic [PW-1:0]  pfx_reg;
    logic           shift_en;

    // Hit: positions up to the match move down. Miss: every occupied position moves down.
    always_comb
    begin
        if (INDEX == 0)
        begin
            shift_en = ctrl.read_go;
        end
        else
        begin
            shift_en = ctrl.read_go && (ctrl.hit ? (IDW'(INDEX) <= pos) : prev_valid);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= (INDEX == 0) ? 1'b1 : prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            if (INDEX == 0)
            begin
                id_reg  <= key;
                wt_reg  <= new_wt;
                pfx_reg <= '0;
            end
            else
            begin
                id_reg  <= prev_id;
                wt_reg  <= prev_wt;
                pfx_reg <= prev_pfx + PW'(new_wt);
            end
        end
        else if (ctrl.load_go && ctrl.hit)
        begin
            if (hit)
            begin
                wt_reg <= new_wt;
            end
            if (IDW'(INDEX) > pos)
            begin
                pfx_reg <= pfx_reg + delta;
            end
        end
    end

    assign hit   = valid_reg && (id_reg == key);
    assign valid = valid_reg;
    assign id    = id_reg;
    assign wt    = wt_reg;
    assign pfx   = pfx_reg;

endmodule

[hw/rtl/lsw_row.sv]
`timescale 1ns / 1ps
// Row of stack cells chained top to bottom, with the one-hot match select.
module lsw_row #(
    parameter int NUM_ITEMS = 512,
    parameter int IDW       = 9,
    parameter int WW        = 16,
    parameter int PW        = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsw_pkg::lsw_ctrl_t ctrl,
    input  logic [IDW-1:0]     key,
    input  logic [IDW-1:0]     pos,
    input  logic [WW-1:0]      new_wt,
    input  logic [PW-1:0]      delta,
    output logic               hit_any,
    output logic [IDW-1:0]     hit_pos,
    output logic [WW-1:0]      hit_wt,
    output logic [PW-1:0]      hit_pfx
);

    import lsw_pkg::*;

    logic           vld  [NUM_ITEMS];
    logic [IDW-1:0] ids  [NUM_ITEMS];
    logic [WW-1:0]  wts  [NUM_ITEMS];
    logic [PW-1:0]  pfxs [NUM_ITEMS];
    logic           hits [NUM_ITEMS];

    for (genvar j = 0; j < NUM_ITEMS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            lsw_cell #(
                .IDW   (IDW),
                .WW    (WW),
                .PW    (PW),
                .INDEX (j)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key),
                .pos        (pos),
                .new_wt     (new_wt),
                .delta      (delta),
                .prev_valid (1'b0),
                .prev_id    ('0),
                .prev_wt    ('0),
                .prev_pfx   ('0),
                .valid      (vld[j]),
                .id         (ids[j]),
                .wt         (wts[j]),
                .pfx        (pfxs[j]),
                .hit        (hits[j])
            );
        end
        else
        begin : g_body
            lsw_cell #(
                .IDW   (IDW),
                .WW    (WW),
                .PW    (PW),
                .INDEX (j)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (key),
                .pos        (pos),
                .new_wt     (new_wt),
                .delta      (delta),
                .prev_valid (vld[j-1]),
                .prev_id    (ids[j-1]),
                .prev_wt    (wts[j-1]),
                .prev_pfx   (pfxs[j-1]),
                .valid      (vld[j]),
                .id         (ids[j]),
                .wt         (wts[j]),
                .pfx        (pfxs[j]),
                .hit        (hits[j])
            );
        end
    end

    // At most one cell matches, so an OR across the row selects it.
    always_comb
    begin
        hit_any = 1'b0;
        hit_pos = '0;
        hit_wt  = '0;
        hit_pfx = '0;
        for (int j = 0; j < NUM_ITEMS; j++)
        begin
            if (hits[j])
            begin
                hit_any = 1'b1;
                hit_pos = hit_pos | IDW'(j);
                hit_wt  = hit_wt | wts[j];
                hit_pfx = hit_pfx | pfxs[j];
            end
        end
    end

endmodule
